[hdl/fbpr_pkg.sv]
// Package with the widths, constants and codes of the flux bitcell PLL recovery block.
package fbpr_pkg;
    localparam int unsigned WORD_BITS      = 32;
    localparam int unsigned MAX_ZEROS_DEF  = 64;
    localparam logic [31:0] ONE_Q16        = 32'h0001_0000;
    localparam logic [15:0] TICKS_RESET    = 16'd144;
    localparam logic [15:0] MASK_RESET     = 16'hFFFF;

    localparam logic [1:0] FUNC_EDGE  = 2'd0;
    localparam logic [1:0] FUNC_FLUSH = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic REG_TICKS = 1'b0;
    localparam logic REG_MASK  = 1'b1;

    typedef struct packed {
        logic [31:0] word;
        logic [15:0] idx;
        logic [31:0] cnt;
    } res_t;
endpackage

[hdl/flux_bitcell_pll_recovery.sv]
// Top level of the flux bitcell PLL recovery block: cell loop, serial divider and result buffer.
//
//  channel | direction | beat contents
//  s_      | in        | tuser: func[1:0]; tdata: edge_time[15:0]
//  m_      | out       | tdata: word, word_index, bit_count, zeros_capped; tlast: last
//  cfg_    | in        | cfg_index 0 bitcell_ticks, 1 word_index_mask
//
// For an edge, one bit is shifted per cycle and the phase error is divided by a restoring
// divider that yields one quotient bit per cycle.
// A flush or an edge sends its results one per cycle when m_tready allows; a start sends none.
// Reset is synchronous and active low; the output register holds a beat while m_tready is low.
module flux_bitcell_pll_recovery
    import fbpr_pkg::*;
#(
    parameter int unsigned MAX_ZEROS = MAX_ZEROS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // edge_time[15:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // word[31:0], word_index[47:32], bit_count[79:48], zeros_capped[80]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int ZC_W = $clog2(MAX_ZEROS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_ALIGN = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_ZERO  = 4'd4;
    localparam logic [3:0] ST_PREP  = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_UPD   = 4'd7;
    localparam logic [3:0] ST_STEP  = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;

    logic [3:0]      st_reg;
    logic [15:0]     ticks_reg, mask_reg;
    logic [31:0]     step_reg, integ_reg, prev_reg, cur_reg, sr_reg, cnt_reg;
    logic            aligned_reg;
    logic [31:0]     cell_reg, edge_reg, dist_reg, diff_reg, quot_reg, err_reg;
    logic [15:0]     rem_reg;
    logic [4:0]      dcnt_reg;
    logic            neg_reg, capped_reg;
    logic [ZC_W-1:0] zc_reg;
    res_t            buf_reg [3];
    logic [1:0]      n_reg, e_reg;
    logic            mv_reg, mlast_reg;
    res_t            mres_reg;
    logic            mcap_reg;

    logic        zero_go, bit_in;
    logic [31:0] sr_next, cnt_next, half, diff_next, div_ext;
    logic [16:0] trial;
    logic        tge;
    logic [32:0] sum33;
    logic [31:0] integ_next, ia, ea;
    logic [4:0]  sh;

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = {7'd0, mcap_reg, mres_reg.cnt, mres_reg.idx, mres_reg.word};

    always_comb begin
        zero_go   = (dist_reg > cell_reg) && (zc_reg < ZC_W'(MAX_ZEROS));
        bit_in    = !zero_go;
        sr_next   = {sr_reg[30:0], bit_in};
        cnt_next  = cnt_reg + 32'd1;
        half      = cell_reg + {31'd0, cell_reg[31]};
        half      = {half[31], half[31:1]};
        diff_next = dist_reg - half;
        div_ext   = {16'd0, (ticks_reg == 16'd0) ? 16'd1 : ticks_reg};
        trial     = {rem_reg, quot_reg[31]};
        tge       = ({15'd0, trial} >= div_ext);
        sum33     = {integ_reg[31], integ_reg} + {err_reg[31], err_reg};
        if (sum33[32] != sum33[31]) begin
            integ_next = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            integ_next = sum33[31:0];
        end
        ia = $signed(integ_next + (integ_next[31] ? 32'd255 : 32'd0)) >>> 8;
        ea = $signed(err_reg + (err_reg[31] ? 32'd7 : 32'd0)) >>> 3;
        sh = 5'd0 - cnt_reg[4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            ticks_reg   <= TICKS_RESET;
            mask_reg    <= MASK_RESET;
            step_reg    <= ONE_Q16;
            integ_reg   <= '0;
            prev_reg    <= '0;
            cur_reg     <= '0;
            sr_reg      <= '1;
            cnt_reg     <= '0;
            aligned_reg <= 1'b0;
            n_reg       <= '0;
            e_reg       <= '0;
            mv_reg      <= 1'b0;
            mlast_reg   <= 1'b0;
            zc_reg      <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_TICKS) begin
                    ticks_reg <= cfg_data;
                end else begin
                    mask_reg <= cfg_data;
                end
            end
            if (mv_reg && m_tready && (st_reg != ST_EMIT || n_reg == 2'd0)) begin
                mv_reg <= 1'b0;
            end
            unique case (st_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        case (s_tuser)
                            FUNC_EDGE: begin
                                edge_reg <= {s_tdata, 16'd0};
                                zc_reg   <= '0;
                                st_reg   <= ST_MUL;
                            end
                            FUNC_FLUSH: begin
                                buf_reg[0].word <= sr_reg << sh;
                                buf_reg[0].idx  <= cnt_reg[20:5] & mask_reg;
                                buf_reg[0].cnt  <= cnt_reg;
                                capped_reg      <= 1'b0;
                                n_reg           <= 2'd1;
                                st_reg          <= ST_EMIT;
                            end
                            FUNC_START: begin
                                step_reg    <= ONE_Q16;
                                integ_reg   <= '0;
                                prev_reg    <= '0;
                                cur_reg     <= '0;
                                sr_reg      <= '1;
                                cnt_reg     <= '0;
                                aligned_reg <= 1'b0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_MUL: begin
                    cell_reg <= step_reg * {16'd0, ticks_reg};
                    st_reg   <= ST_ALIGN;
                end
                ST_ALIGN: begin
                    if (!aligned_reg) begin
                        cur_reg     <= edge_reg - (cell_reg >> 1);
                        prev_reg    <= edge_reg - (cell_reg >> 1) - cell_reg;
                        aligned_reg <= 1'b1;
                    end
                    st_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    dist_reg <= edge_reg - cur_reg;
                    if ((edge_reg - prev_reg) < (cur_reg - prev_reg)) begin
                        st_reg <= ST_IDLE;
                    end else begin
                        st_reg <= ST_ZERO;
                    end
                end
                ST_ZERO: begin
                    sr_reg  <= sr_next;
                    cnt_reg <= cnt_next;
                    if (cnt_next[4:0] == 5'd0 && n_reg != 2'd3) begin
                        buf_reg[n_reg].word <= sr_next;
                        buf_reg[n_reg].idx  <= cnt_reg[20:5] & mask_reg;
                        buf_reg[n_reg].cnt  <= cnt_next;
                        n_reg               <= n_reg + 2'd1;
                    end
                    if (zero_go) begin
                        zc_reg   <= zc_reg + ZC_W'(1);
                        dist_reg <= dist_reg - cell_reg;
                        cur_reg  <= cur_reg + cell_reg;
                    end else begin
                        capped_reg <= (zc_reg >= ZC_W'(MAX_ZEROS));
                        diff_reg   <= diff_next;
                        prev_reg   <= cur_reg;
                        cur_reg    <= cur_reg + cell_reg;
                        st_reg     <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    neg_reg  <= diff_reg[31];
                    quot_reg <= diff_reg[31] ? (32'd0 - diff_reg) : diff_reg;
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    st_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= tge ? 16'(trial - div_ext[16:0]) : trial[15:0];
                    quot_reg <= {quot_reg[30:0], tge};
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (dcnt_reg == 5'd31) begin
                        st_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    err_reg <= neg_reg ? (32'd0 - quot_reg) : quot_reg;
                    st_reg  <= ST_STEP;
                end
                ST_STEP: begin
                    integ_reg <= integ_next;
                    err_reg   <= err_reg;
                    st_reg    <= ST_EMIT;
                    step_reg  <= ONE_Q16 + ea + ia;
                end
                ST_EMIT: begin
                    if (n_reg == 2'd0) begin
                        st_reg <= ST_IDLE;
                    end else if (!mv_reg || m_tready) begin
                        mv_reg    <= 1'b1;
                        mres_reg  <= buf_reg[e_reg];
                        mcap_reg  <= capped_reg;
                        mlast_reg <= (e_reg == n_reg - 2'd1);
                        if (e_reg == n_reg - 2'd1) begin
                            e_reg  <= '0;
                            n_reg  <= '0;
                            st_reg <= ST_IDLE;
                        end else begin
                            e_reg <= e_reg + 2'd1;
                        end
                    end
                end
                default: begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_zero_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        zc_reg <= ZC_W'(MAX_ZEROS)) else $error("zero run passed its cap");
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE) |-> (n_reg == 2'd0 && e_reg == 2'd0))
        else $error("result buffer not empty in idle");
    a_emit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_EMIT && n_reg != 2'd0) |-> (e_reg < n_reg))
        else $error("emit index past buffer fill");
`endif
endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the flux bitcell PLL recovery block.
`timescale 1ns / 1ps

module tb;
    import fbpr_pkg::*;

    typedef struct {
        logic [31:0] word;
        logic [15:0] idx;
        logic [31:0] cnt;
        logic        capped;
        logic        last;
    } beat_t;

    typedef struct {
        logic [1:0]  func;
        logic [15:0] etime;
        bit          typed;
        logic [31:0] word;
        logic [15:0] idx;
        logic [31:0] cnt;
    } row_t;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = FUNC_EDGE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_TICKS;
    logic [15:0] cfg_data = '0;

    flux_bitcell_pll_recovery dut (.*);

    // Predictor state.
    logic [15:0] ticks_q = TICKS_RESET;
    logic [15:0] mask_q = MASK_RESET;
    logic [31:0] osc_step, prev_start, cur_start, shreg, cells;
    int          integ;
    bit          locked;

    beat_t words_due[$];
    int    errors = 0;
    int    beats_seen = 0;
    int    items_sent = 0;
    int    capped_seen = 0;
    int    tx_idle_pct = 0;
    int    rx_idle_pct = 0;
    int    hold_req = 0;
    int    hold_cnt = 0;
    int    cycles = 0;

    logic [15:0] tick_set [6] = '{16'd144, 16'd40, 16'd0, 16'd65535, 16'd1, 16'd96};
    logic [15:0] mask_set [6] = '{16'h00FF, 16'h0007, 16'h0000, 16'hFFFF, 16'h0F0F, 16'h001F};
    int          per_phase [6] = '{60, 60, 12, 12, 12, 40};

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic void pll_clear();
        osc_step = ONE_Q16;
        integ = 0;
        prev_start = '0;
        cur_start = '0;
        shreg = '1;
        cells = '0;
        locked = 1'b0;
    endfunction

    function automatic void push_cell(bit b, ref beat_t outs[$]);
        beat_t r;
        shreg = {shreg[30:0], b};
        cells = cells + 1;
        if (cells[4:0] == 5'd0 && outs.size() < 3) begin
            r.word = shreg;
            r.idx = 16'(((cells - 1) >> 5) & {16'd0, mask_q});
            r.cnt = cells;
            r.capped = 1'b0;
            r.last = 1'b0;
            outs.push_back(r);
        end
    endfunction

    function automatic void recover_cells(logic [1:0] func, logic [15:0] etime);
        beat_t       outs[$];
        beat_t       r;
        logic [31:0] cell_len, edge_ph, dist_ph;
        int          nzero, half, diff, err, divisor;
        longint      sum;
        bit          cap;
        if (func == FUNC_START) begin
            pll_clear();
        end else if (func == FUNC_FLUSH) begin
            r.word = shreg << ((32'd0 - cells) & 32'd31);
            r.idx = 16'((cells >> 5) & {16'd0, mask_q});
            r.cnt = cells;
            r.capped = 1'b0;
            r.last = 1'b1;
            words_due.push_back(r);
        end else if (func == FUNC_EDGE) begin
            cell_len = osc_step * {16'd0, ticks_q};
            edge_ph = {etime, 16'd0};
            divisor = (ticks_q != 0) ? int'(ticks_q) : 1;
            if (!locked) begin
                cur_start = edge_ph - (cell_len >> 1);
                prev_start = cur_start - cell_len;
                locked = 1'b1;
            end
            if (edge_ph - prev_start >= cur_start - prev_start) begin
                dist_ph = edge_ph - cur_start;
                nzero = 0;
                while (dist_ph > cell_len && nzero < 64) begin
                    push_cell(1'b0, outs);
                    nzero++;
                    dist_ph = dist_ph - cell_len;
                    cur_start = cur_start + cell_len;
                end
                cap = (nzero >= 64);
                push_cell(1'b1, outs);
                half = $signed(cell_len) / 2;
                diff = $signed(dist_ph - half);
                err = diff / divisor;
                prev_start = cur_start;
                cur_start = cur_start + cell_len;
                sum = longint'(integ) + err;
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                integ = int'(sum);
                osc_step = 32'(65536 + integ / 256 + err / 8);
                foreach (outs[k]) begin
                    outs[k].capped = cap;
                    outs[k].last = (k == outs.size() - 1);
                    words_due.push_back(outs[k]);
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        beat_t e;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d beats outstanding", $time, words_due.size());
            $display("*** FAILED ***");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            if (words_due.size() == 0) begin
                $display("%0t unexpected beat %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = words_due.pop_front();
                if (e.capped) capped_seen++;
                if (m_tdata[31:0] !== e.word) begin
                    $display("%0t word exp %h got %h", $time, e.word, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[47:32] !== e.idx) begin
                    $display("%0t word_index exp %h got %h", $time, e.idx, m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[79:48] !== e.cnt) begin
                    $display("%0t bit_count exp %0d got %0d", $time, e.cnt, m_tdata[79:48]);
                    errors++;
                end
                if (m_tdata[80] !== e.capped) begin
                    $display("%0t zeros_capped exp %b got %b", $time, e.capped, m_tdata[80]);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t last exp %b got %b", $time, e.last, m_tlast);
                    errors++;
                end
            end
        end
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_beat(logic [1:0] func, logic [15:0] etime);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= etime;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        recover_cells(func, etime);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] ticks, logic [15:0] mask);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_TICKS;
        cfg_data <= ticks;
        @(posedge aclk);
        cfg_index <= REG_MASK;
        cfg_data <= mask;
        @(posedge aclk);
        cfg_we <= 1'b0;
        ticks_q = ticks;
        mask_q = mask;
    endtask

    row_t plan[$] = '{
        '{FUNC_FLUSH, 16'h0000, 1'b1, 32'hFFFF_FFFF, 16'h0000, 32'd0},
        '{FUNC_NOP,   16'hFFFF, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h0000, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h0050, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h0090, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h0120, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h0400, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h1000, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h5000, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h5090, 1'b0, '0, '0, '0},
        '{FUNC_FLUSH, 16'hFFFF, 1'b0, '0, '0, '0},
        '{FUNC_START, 16'h0000, 1'b0, '0, '0, '0},
        '{FUNC_FLUSH, 16'h0000, 1'b1, 32'hFFFF_FFFF, 16'h0000, 32'd0},
        '{FUNC_EDGE,  16'hFFFF, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h0089, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h8000, 1'b0, '0, '0, '0},
        '{FUNC_EDGE,  16'h8121, 1'b0, '0, '0, '0},
        '{FUNC_FLUSH, 16'h0000, 1'b0, '0, '0, '0}
    };

    initial begin
        logic [15:0] t;
        int          pick, k, gap;
        beat_t       typed_beat;
        pll_clear();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            send_beat(plan[i].func, plan[i].etime);
            if (plan[i].typed) begin
                typed_beat = '{plan[i].word, plan[i].idx, plan[i].cnt, 1'b0, 1'b1};
                void'(words_due.pop_back());
                words_due.push_back(typed_beat);
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            set_regs(tick_set[ph], mask_set[ph]);
            tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 46 : 0;
            rx_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 30 : 0;
            send_beat(FUNC_START, 16'($urandom));
            t = 16'($urandom);
            k = 0;
            while (k < per_phase[ph] || (ph == 5 && beats_seen + words_due.size() < 60
                                         && k < 2000)) begin
                if (ph == 0 && k == 10) hold_req = 600;
                if (ph == 1 && k == 20) drain();
                pick = $urandom_range(99);
                if (pick < 3) begin
                    send_beat(FUNC_FLUSH, 16'($urandom));
                end else if (pick < 5) begin
                    send_beat(FUNC_NOP, 16'($urandom));
                end else if (pick < 6) begin
                    send_beat(FUNC_START, 16'($urandom));
                end else begin
                    if (pick < 70) gap = $urandom_range(3, 1) * ticks_q;
                    else if (pick < 85) gap = $urandom_range(10, 4) * ticks_q;
                    else if (pick < 90) gap = $urandom_range(70, 60) * ticks_q;
                    else if (pick < 95) gap = $urandom_range(ticks_q / 2);
                    else gap = $urandom;
                    gap = gap + $signed($urandom_range(ticks_q / 2)) - int'(ticks_q / 4);
                    t = t + 16'(gap);
                    send_beat(FUNC_EDGE, t);
                end
                k++;
            end
        end

        drain();
        $display("Sent %0d items over six register settings; checked %0d result beats,",
                 items_sent, beats_seen);
        $display("%0d of them from capped zero runs, with stalls and idles on both sides.",
                 capped_seen);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
